[design/cpl_pkg.sv]
// Shared types, constants and register codes of the CAN PWM light controller.
`default_nettype none

package cpl_pkg;

   // Widths and counts
   localparam int DUTY_W           = 8;
   localparam int MAX_CHANNELS     = 8;
   localparam int CHAN_IDX_W       = 3;
   localparam int ID_W             = 11;
   localparam int ADDR_W           = 2;
   localparam int PERIOD_W         = 16;
   localparam int FAIL_W           = 4;
   localparam int CSR_INDEX_W      = 2;
   localparam int CSR_DATA_W       = 16;
   localparam int CHANNELS_DEFAULT = 8;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Frame identifiers (before module address offset)
   localparam logic [ID_W-1:0] ID_BRIGHT_BASE = 11'h015;
   localparam logic [ID_W-1:0] ID_TOGGLE_BASE = 11'h018;
   localparam logic [ID_W-1:0] ID_STATUS_BASE = 11'h01B;

   localparam logic [DUTY_W-1:0] FULL_DUTY = 8'hFF;
   localparam logic [DUTY_W-1:0] ZERO_DUTY = 8'h00;
   localparam logic [7:0] SEL_ALL_SET = 8'd8;
   localparam logic [7:0] SEL_ALL_ON  = 8'd9;

   localparam logic [FAIL_W-1:0]   FAIL_MAX    = 4'hF;
   localparam logic [PERIOD_W-1:0] ELAPSED_MAX = 16'hFFFF;

   // Configuration reset values
   localparam logic [ADDR_W-1:0]   RST_MODULE_ADDRESS = 2'd0;
   localparam logic [PERIOD_W-1:0] RST_STATUS_PERIOD  = 16'd33;
   localparam logic [PERIOD_W-1:0] RST_PROBE_PERIOD   = 16'd2000;
   localparam logic [FAIL_W-1:0]   RST_FAIL_THRESHOLD = 4'd3;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_MODULE_ADDRESS   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STATUS_PERIOD_MS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROBE_PERIOD_MS  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAIL_THRESHOLD   = 2'd3;

   // Request kinds
   typedef enum logic [1:0] {
      CMD_FRAME = 2'd0,
      CMD_ALERT = 2'd1,
      CMD_TICK  = 2'd2,
      CMD_NONE  = 2'd3
   } cpl_cmd_type;

   // Duty actions decided by the front end
   typedef enum logic [1:0] {
      ACT_NONE    = 2'd0,
      ACT_TOGGLE  = 2'd1,
      ACT_SET_ONE = 2'd2,
      ACT_SET_ALL = 2'd3
   } cpl_act_type;

   // Classified request as it travels through the queue
   typedef struct packed {
      cpl_cmd_type           cmd;
      cpl_act_type           act;
      logic [CHAN_IDX_W-1:0] chan;
      logic [DUTY_W-1:0]     value;
      logic                  bus_off;
      logic                  recovered;
      logic                  tx_failed;
      logic                  tx_success;
   } cpl_op_type;

   localparam int OP_W = $bits(cpl_op_type);

endpackage

`default_nettype wire

[design/cpl_front.sv]
// Front end: accepts requests and classifies frames into duty actions.
`default_nettype none

module cpl_front #(
   parameter int CHANNELS = cpl_pkg::CHANNELS_DEFAULT
) (
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_cmd,
   input  wire logic [cpl_pkg::ID_W-1:0]      req_frame_id,
   input  wire logic                          req_frame_rtr,
   input  wire logic [3:0]                    req_frame_length,
   input  wire logic [7:0]                    req_data_first,
   input  wire logic [7:0]                    req_data_second,
   input  wire logic                          req_alert_bus_off,
   input  wire logic                          req_alert_recovered,
   input  wire logic                          req_alert_tx_failed,
   input  wire logic                          req_alert_tx_success,
   input  wire logic [cpl_pkg::ADDR_W-1:0]    module_address,
   input  wire logic                          queue_full,
   output logic                               push,
   output cpl_pkg::cpl_op_type                op
);

   logic [cpl_pkg::ID_W-1:0] toggle_id;
   logic [cpl_pkg::ID_W-1:0] bright_id;
   logic                     len_one;
   logic                     len_two;
   logic                     chan_ok;

   // Accept whenever the queue has room
   assign req_ready = ~queue_full;
   assign push      = req_valid & ~queue_full;

   assign toggle_id = cpl_pkg::ID_TOGGLE_BASE + {9'd0, module_address};
   assign bright_id = cpl_pkg::ID_BRIGHT_BASE + {9'd0, module_address};
   assign len_one   = (req_frame_length != 4'd0);
   assign len_two   = (req_frame_length >= 4'd2);
   assign chan_ok   = (req_data_first < 8'(CHANNELS));

   // Classify the request
   always_comb begin
      op            = '0;
      op.cmd        = cpl_pkg::cpl_cmd_type'(req_cmd);
      op.act        = cpl_pkg::ACT_NONE;
      op.chan       = req_data_first[cpl_pkg::CHAN_IDX_W-1:0];
      op.value      = req_data_second;
      op.bus_off    = req_alert_bus_off;
      op.recovered  = req_alert_recovered;
      op.tx_failed  = req_alert_tx_failed;
      op.tx_success = req_alert_tx_success;
      if (op.cmd == cpl_pkg::CMD_FRAME && !req_frame_rtr) begin
         if (req_frame_id == toggle_id) begin
            if (len_one) begin
               if (chan_ok) begin
                  op.act = cpl_pkg::ACT_TOGGLE;
               end else if (req_data_first == cpl_pkg::SEL_ALL_SET) begin
                  op.act   = cpl_pkg::ACT_SET_ALL;
                  op.value = (len_two && req_data_second == 8'd0) ?
                             cpl_pkg::ZERO_DUTY : cpl_pkg::FULL_DUTY;
               end else if (req_data_first == cpl_pkg::SEL_ALL_ON && len_two &&
                            req_data_second == 8'd1) begin
                  op.act   = cpl_pkg::ACT_SET_ALL;
                  op.value = cpl_pkg::FULL_DUTY;
               end
            end
         end else if (req_frame_id == bright_id) begin
            if (len_two && chan_ok) begin
               op.act = cpl_pkg::ACT_SET_ONE;
            end
         end
      end
   end

endmodule

`default_nettype wire

[design/cpl_queue.sv]
// Short first-in first-out queue between the front end and the back end.
`default_nettype none

module cpl_queue #(
   parameter int WIDTH = cpl_pkg::OP_W,
   parameter int DEPTH = cpl_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  not_empty
);

   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0]   PTR_LAST  = PTR_W'(DEPTH - 1);
   localparam logic [COUNT_W-1:0] COUNT_TOP = COUNT_W'(DEPTH);

   logic [WIDTH-1:0]   entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == COUNT_TOP);
   assign not_empty = (count_ff != '0);
   assign pop_data  = entries_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed entry
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[design/cpl_back.sv]
// Back end: applies classified requests to duties and link state, holds the response.
`default_nettype none

module cpl_back #(
   parameter int CHANNELS = cpl_pkg::CHANNELS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             op_valid,
   input  wire cpl_pkg::cpl_op_type              op,
   output logic                                  pop,
   input  wire logic [cpl_pkg::ADDR_W-1:0]       module_address,
   input  wire logic [cpl_pkg::PERIOD_W-1:0]     status_period_ms,
   input  wire logic [cpl_pkg::PERIOD_W-1:0]     probe_period_ms,
   input  wire logic [cpl_pkg::FAIL_W-1:0]       fail_threshold,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [cpl_pkg::MAX_CHANNELS*cpl_pkg::DUTY_W-1:0] rsp_duty_values,
   output logic                                  rsp_status_send,
   output logic [cpl_pkg::ID_W-1:0]              rsp_status_id,
   output logic                                  rsp_link_probing,
   output logic                                  rsp_bus_off_flag
);

   localparam int DUTY_W = cpl_pkg::DUTY_W;
   localparam int NCH    = cpl_pkg::MAX_CHANNELS;

   logic [DUTY_W-1:0]            duty_ff [NCH];
   logic [DUTY_W-1:0]            duty_in [NCH];
   logic                         probing_ff, probing_in;
   logic                         bus_off_ff, bus_off_in;
   logic [cpl_pkg::FAIL_W-1:0]   fail_ff, fail_in;
   logic [cpl_pkg::PERIOD_W-1:0] elapsed_ff, elapsed_in;
   logic [cpl_pkg::PERIOD_W-1:0] period;
   logic                         send;
   logic [NCH*DUTY_W-1:0]        packed_duty;

   logic                         rsp_valid_ff;
   logic [NCH*DUTY_W-1:0]        rsp_duty_ff;
   logic                         rsp_send_ff;
   logic [cpl_pkg::ID_W-1:0]     rsp_id_ff;
   logic                         rsp_probing_ff;
   logic                         rsp_bus_off_ff;

   // Take the next request when the response register is free or draining
   assign pop    = op_valid & (~rsp_valid_ff | rsp_ready);
   assign period = probing_ff ? probe_period_ms : status_period_ms;

   // Execute one request
   always_comb begin
      for (int i = 0; i < NCH; i++) begin
         duty_in[i] = duty_ff[i];
      end
      probing_in = probing_ff;
      bus_off_in = bus_off_ff;
      fail_in    = fail_ff;
      elapsed_in = elapsed_ff;
      send       = 1'b0;
      if (pop) begin
         case (op.cmd)
            cpl_pkg::CMD_FRAME: begin
               // Any frame ends probing
               if (probing_ff) begin
                  probing_in = 1'b0;
                  fail_in    = '0;
               end
               case (op.act)
                  cpl_pkg::ACT_TOGGLE: begin
                     duty_in[op.chan] = (duty_ff[op.chan] != cpl_pkg::ZERO_DUTY) ?
                                        cpl_pkg::ZERO_DUTY : cpl_pkg::FULL_DUTY;
                  end
                  cpl_pkg::ACT_SET_ONE: begin
                     duty_in[op.chan] = op.value;
                  end
                  cpl_pkg::ACT_SET_ALL: begin
                     for (int i = 0; i < NCH; i++) begin
                        if (i < CHANNELS) begin
                           duty_in[i] = op.value;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
            cpl_pkg::CMD_ALERT: begin
               if (op.bus_off) begin
                  bus_off_in = 1'b1;
               end else begin
                  if (op.recovered) begin
                     bus_off_in = 1'b0;
                     fail_in    = '0;
                     probing_in = 1'b1;
                  end
                  // Count failures only while active
                  if (op.tx_failed && !probing_in) begin
                     if (fail_in != cpl_pkg::FAIL_MAX) begin
                        fail_in = fail_in + 1'b1;
                     end
                     if (fail_in >= fail_threshold) begin
                        probing_in = 1'b1;
                     end
                  end
                  if (op.tx_success) begin
                     probing_in = 1'b0;
                     fail_in    = '0;
                  end
               end
            end
            cpl_pkg::CMD_TICK: begin
               if (elapsed_ff != cpl_pkg::ELAPSED_MAX) begin
                  elapsed_in = elapsed_ff + 1'b1;
               end
               if (!bus_off_ff && elapsed_in >= period) begin
                  send       = 1'b1;
                  elapsed_in = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Pack duties, channel 0 in the low byte
   always_comb begin
      for (int i = 0; i < NCH; i++) begin
         packed_duty[i*DUTY_W +: DUTY_W] = (i < CHANNELS) ? duty_in[i] : cpl_pkg::ZERO_DUTY;
      end
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NCH; i++) begin
            duty_ff[i] <= cpl_pkg::ZERO_DUTY;
         end
         probing_ff   <= 1'b0;
         bus_off_ff   <= 1'b0;
         fail_ff      <= '0;
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < NCH; i++) begin
            duty_ff[i] <= duty_in[i];
         end
         probing_ff <= probing_in;
         bus_off_ff <= bus_off_in;
         fail_ff    <= fail_in;
         elapsed_ff <= elapsed_in;
         if (pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Load the response register
   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_duty_ff    <= packed_duty;
         rsp_send_ff    <= send;
         rsp_id_ff      <= cpl_pkg::ID_STATUS_BASE + {9'd0, module_address};
         rsp_probing_ff <= probing_in;
         rsp_bus_off_ff <= bus_off_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_duty_values  = rsp_duty_ff;
   assign rsp_status_send  = rsp_send_ff;
   assign rsp_status_id    = rsp_id_ff;
   assign rsp_link_probing = rsp_probing_ff;
   assign rsp_bus_off_flag = rsp_bus_off_ff;

endmodule

`default_nettype wire

[design/can_pwm_light_controller.sv]
// Usage: the request channel (req_*) carries one received frame, bus alert or
// millisecond tick per request; every request yields exactly one response on
// the rsp_* channel with the eight packed duties, a status-send flag, the
// status frame identifier, the link state and the bus-off flag.
// The csr_* channel writes the module address, the two status periods and the
// failure threshold; it is always ready and should be used while idle.
// Throughput: one request per cycle while req_ready is high. A request passes
// the front classifier into a two-entry queue, then the back end applies it
// and registers the response; between acceptance and rsp_valid lie the queue
// entry and the response register.
// The queue limits how far the front end runs ahead; when the receiver holds
// rsp_ready low the response stays put, the queue fills and req_ready drops
// after two more requests. Reset (synchronous) clears duties, link state,
// counters and the queue, and restores the configuration defaults; no
// response is pending after reset.
`default_nettype none

module can_pwm_light_controller #(
   parameter int CHANNELS    = cpl_pkg::CHANNELS_DEFAULT,
   parameter int QUEUE_DEPTH = cpl_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [1:0]                        req_cmd,
   input  wire logic [10:0]                       req_frame_id,
   input  wire logic                              req_frame_rtr,
   input  wire logic [3:0]                        req_frame_length,
   input  wire logic [7:0]                        req_data_first,
   input  wire logic [7:0]                        req_data_second,
   input  wire logic                              req_alert_bus_off,
   input  wire logic                              req_alert_recovered,
   input  wire logic                              req_alert_tx_failed,
   input  wire logic                              req_alert_tx_success,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [63:0]                            rsp_duty_values,
   output logic                                   rsp_status_send,
   output logic [10:0]                            rsp_status_id,
   output logic                                   rsp_link_probing,
   output logic                                   rsp_bus_off_flag,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [cpl_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [cpl_pkg::CSR_DATA_W-1:0]    csr_data
);

   logic [cpl_pkg::ADDR_W-1:0]   mod_addr_ff, mod_addr_in;
   logic [cpl_pkg::PERIOD_W-1:0] status_period_ff, status_period_in;
   logic [cpl_pkg::PERIOD_W-1:0] probe_period_ff, probe_period_in;
   logic [cpl_pkg::FAIL_W-1:0]   fail_thr_ff, fail_thr_in;

   logic                         push;
   logic                         pop;
   logic                         queue_full;
   logic                         queue_not_empty;
   cpl_pkg::cpl_op_type          front_op;
   logic [cpl_pkg::OP_W-1:0]     head_bits;

   // Configuration writes
   assign csr_ready = 1'b1;

   always_comb begin
      mod_addr_in      = mod_addr_ff;
      status_period_in = status_period_ff;
      probe_period_in  = probe_period_ff;
      fail_thr_in      = fail_thr_ff;
      if (csr_valid) begin
         case (csr_index)
            cpl_pkg::CSR_MODULE_ADDRESS:   mod_addr_in      = csr_data[cpl_pkg::ADDR_W-1:0];
            cpl_pkg::CSR_STATUS_PERIOD_MS: status_period_in = csr_data;
            cpl_pkg::CSR_PROBE_PERIOD_MS:  probe_period_in  = csr_data;
            cpl_pkg::CSR_FAIL_THRESHOLD:   fail_thr_in      = csr_data[cpl_pkg::FAIL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_addr_ff      <= cpl_pkg::RST_MODULE_ADDRESS;
         status_period_ff <= cpl_pkg::RST_STATUS_PERIOD;
         probe_period_ff  <= cpl_pkg::RST_PROBE_PERIOD;
         fail_thr_ff      <= cpl_pkg::RST_FAIL_THRESHOLD;
      end else begin
         mod_addr_ff      <= mod_addr_in;
         status_period_ff <= status_period_in;
         probe_period_ff  <= probe_period_in;
         fail_thr_ff      <= fail_thr_in;
      end
   end

   // Classify requests
   cpl_front #(
      .CHANNELS (CHANNELS)
   ) u_front (
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_cmd              (req_cmd),
      .req_frame_id         (req_frame_id),
      .req_frame_rtr        (req_frame_rtr),
      .req_frame_length     (req_frame_length),
      .req_data_first       (req_data_first),
      .req_data_second      (req_data_second),
      .req_alert_bus_off    (req_alert_bus_off),
      .req_alert_recovered  (req_alert_recovered),
      .req_alert_tx_failed  (req_alert_tx_failed),
      .req_alert_tx_success (req_alert_tx_success),
      .module_address       (mod_addr_ff),
      .queue_full           (queue_full),
      .push                 (push),
      .op                   (front_op)
   );

   // Decouple front and back
   cpl_queue #(
      .WIDTH (cpl_pkg::OP_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_op),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (head_bits),
      .not_empty (queue_not_empty)
   );

   // Apply requests and hold the response
   cpl_back #(
      .CHANNELS (CHANNELS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .op_valid         (queue_not_empty),
      .op               (cpl_pkg::cpl_op_type'(head_bits)),
      .pop              (pop),
      .module_address   (mod_addr_ff),
      .status_period_ms (status_period_ff),
      .probe_period_ms  (probe_period_ff),
      .fail_threshold   (fail_thr_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_duty_values  (rsp_duty_values),
      .rsp_status_send  (rsp_status_send),
      .rsp_status_id    (rsp_status_id),
      .rsp_link_probing (rsp_link_probing),
      .rsp_bus_off_flag (rsp_bus_off_flag)
   );

`ifndef SYNTHESIS
   // No status frame is requested while in bus-off
   a_no_send_bus_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_status_send && rsp_bus_off_flag))
      else $error("status send raised during bus-off");

   // Status identifier follows the configured module address
   a_status_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status_id == cpl_pkg::ID_STATUS_BASE + {9'd0, mod_addr_ff}))
      else $error("status identifier does not match module address");

   // No response is pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // A popped request always produces a response in the next cycle
   a_pop_rsp: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid)
      else $error("popped request did not reach the response register");
`endif

endmodule

`default_nettype wire
